// ===== design/prrs_pkg.sv =====
// ----------------------------------------------------------------------------
// prrs_pkg
// shared constants, codes and types of the priority round robin scheduler
// ----------------------------------------------------------------------------
package prrs_pkg;

   localparam int QUEUE_DEPTH  = 16;
   localparam int ID_BITS      = 8;
   localparam int PRIO_BITS    = 8;
   localparam int BURST_BITS   = 16;
   localparam int IDX_BITS     = $clog2(QUEUE_DEPTH);
   localparam int CNT_BITS     = $clog2(QUEUE_DEPTH + 1);
   localparam int QUANTUM_BITS = 8;
   localparam int TIME_BITS    = 32;

   localparam logic [QUANTUM_BITS-1:0] QUANTUM_RESET = 8'd4;

   localparam logic CMD_ARRIVE = 1'b0;
   localparam logic CMD_TICK   = 1'b1;

   localparam logic [1:0] STATUS_ACCEPT = 2'd0;
   localparam logic [1:0] STATUS_REJECT = 2'd1;
   localparam logic [1:0] STATUS_RAN    = 2'd2;
   localparam logic [1:0] STATUS_IDLE   = 2'd3;

   typedef struct packed {
      logic [ID_BITS-1:0]    id;
      logic [PRIO_BITS-1:0]  prio;
      logic [BURST_BITS-1:0] remaining;
   } entry_type;

   typedef struct packed {
      logic                found;
      logic [IDX_BITS-1:0] idx;
      entry_type           entry;
   } wave_type;

   typedef struct packed {
      logic                push_one;
      logic                push_two;
      logic [CNT_BITS-1:0] push_idx;
      logic                shift;
      logic [IDX_BITS-1:0] shift_from;
      logic [CNT_BITS-1:0] count;
   } cell_ctl_type;

endpackage

// ===== design/prrs_cell.sv =====
// ----------------------------------------------------------------------------
// prrs_cell
// one ready queue slot: holds a task, takes pushes, shifts toward the head
// and passes the running best-priority search wave to its neighbor
// ----------------------------------------------------------------------------
module prrs_cell
   import prrs_pkg::*;
(
   input  logic                clock,
   input  logic [IDX_BITS-1:0] cell_idx,
   input  cell_ctl_type        ctl,
   input  entry_type           push_a,
   input  entry_type           push_b,
   input  entry_type           nxt_entry,
   input  wave_type            prev_wave,
   output entry_type           entry,
   output wave_type            wave
);

   entry_type           entry_ff;
   entry_type           entry_in;
   wave_type            wave_ff;
   wave_type            wave_in;
   logic [CNT_BITS-1:0] idx_wide;
   logic                occupied;

   assign idx_wide = CNT_BITS'(cell_idx);
   assign occupied = idx_wide < ctl.count;

   always_comb begin
      entry_in = entry_ff;
      if (ctl.push_one && idx_wide == ctl.push_idx) begin
         entry_in = push_a;
      end else if (ctl.push_two && idx_wide == ctl.push_idx + 1'b1) begin
         entry_in = push_b;
      end else if (ctl.shift && cell_idx >= ctl.shift_from) begin
         entry_in = nxt_entry;
      end
   end

   // earliest slot wins on equal priority
   always_comb begin
      wave_in = prev_wave;
      if (occupied && (!prev_wave.found || entry_ff.prio > prev_wave.entry.prio)) begin
         wave_in.found = 1'b1;
         wave_in.idx   = cell_idx;
         wave_in.entry = entry_ff;
      end
   end

   always_ff @(posedge clock) begin
      entry_ff <= entry_in;
      wave_ff  <= wave_in;
   end

   assign entry = entry_ff;
   assign wave  = wave_ff;

endmodule

// ===== design/priority_round_robin_scheduler_core.sv =====
// ----------------------------------------------------------------------------
// priority_round_robin_scheduler_core
// preemptive priority scheduler with round robin among equal priorities
// ----------------------------------------------------------------------------
// flow: an arrival's result is registered from S_EXEC, a tick's from S_RUN after
// S_EXEC, or after S_EXEC, S_SEARCH and S_EXTRACT when a new task must be picked:
// the search wave walks the cell row one slot per cycle
// throughput: one item in flight; the next transfer is taken once the result is
// registered
// reset: synchronous, queue empty, no task running, time zero, quantum 4
// ----------------------------------------------------------------------------
module priority_round_robin_scheduler_core
   import prrs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [7:0]  req_task_id,
   input  logic [7:0]  req_task_priority,
   input  logic [15:0] req_burst,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_status,
   output logic [7:0]  rsp_run_id,
   output logic [7:0]  rsp_run_priority,
   output logic        rsp_finished,
   output logic [31:0] rsp_finish_time,
   output logic        rsp_preempted,
   input  logic        csr_write_en,
   input  logic [7:0]  csr_write_data
);

   localparam logic [2:0] S_IDLE    = 3'd0;
   localparam logic [2:0] S_EXEC    = 3'd1;
   localparam logic [2:0] S_SEARCH  = 3'd2;
   localparam logic [2:0] S_EXTRACT = 3'd3;
   localparam logic [2:0] S_RUN     = 3'd4;

   logic [2:0]              state_ff, state_in;
   logic                    cmd_ff, cmd_in;
   logic [ID_BITS-1:0]      id_ff, id_in;
   logic [PRIO_BITS-1:0]    prio_ff, prio_in;
   logic [BURST_BITS-1:0]   burst_ff, burst_in;
   logic [CNT_BITS-1:0]     count_ff, count_in;
   logic                    active_valid_ff, active_valid_in;
   entry_type               active_ff, active_in;
   logic [QUANTUM_BITS-1:0] slice_ff, slice_in;
   logic [TIME_BITS-1:0]    time_ff, time_in;
   logic [QUANTUM_BITS-1:0] quantum_ff, quantum_in;
   logic [IDX_BITS-1:0]     srch_cnt_ff, srch_cnt_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [1:0]              status_ff, status_in;
   logic [7:0]              run_id_ff, run_id_in;
   logic [7:0]              run_prio_ff, run_prio_in;
   logic                    finished_ff, finished_in;
   logic [TIME_BITS-1:0]    finish_time_ff, finish_time_in;
   logic                    preempted_ff, preempted_in;

   cell_ctl_type            ctl;
   entry_type               push_a;
   entry_type               push_b;
   entry_type               cell_entry [QUEUE_DEPTH];
   wave_type                cell_wave  [QUEUE_DEPTH];
   wave_type                wave_none;

   logic                    out_free;
   logic [CNT_BITS-1:0]     held;
   logic [QUANTUM_BITS-1:0] limit;
   logic [BURST_BITS-1:0]   rem_next;
   logic [QUANTUM_BITS-1:0] slice_next;
   entry_type               new_entry;

   assign wave_none = '0;

   genvar k;
   generate
      for (k = 0; k < QUEUE_DEPTH; k++) begin : g_cell
         entry_type nxt;
         wave_type  prv;
         if (k == QUEUE_DEPTH - 1) begin : g_last
            assign nxt = cell_entry[k];
         end else begin : g_mid
            assign nxt = cell_entry[k+1];
         end
         if (k == 0) begin : g_first
            assign prv = wave_none;
         end else begin : g_rest
            assign prv = cell_wave[k-1];
         end
         prrs_cell u_cell (
            .clock     (clock),
            .cell_idx  (IDX_BITS'(k)),
            .ctl       (ctl),
            .push_a    (push_a),
            .push_b    (push_b),
            .nxt_entry (nxt),
            .prev_wave (prv),
            .entry     (cell_entry[k]),
            .wave      (cell_wave[k])
         );
      end
   endgenerate

   assign out_free   = !rsp_valid_ff || !rsp_stall;
   assign held       = count_ff + CNT_BITS'(active_valid_ff);
   assign limit      = (quantum_ff == '0) ? QUANTUM_BITS'(1) : quantum_ff;
   assign rem_next   = active_ff.remaining - 1'b1;
   assign slice_next = slice_ff + 1'b1;

   always_comb begin
      new_entry.id        = id_ff;
      new_entry.prio      = prio_ff;
      new_entry.remaining = burst_ff;
   end

   always_comb begin
      state_in        = state_ff;
      cmd_in          = cmd_ff;
      id_in           = id_ff;
      prio_in         = prio_ff;
      burst_in        = burst_ff;
      count_in        = count_ff;
      active_valid_in = active_valid_ff;
      active_in       = active_ff;
      slice_in        = slice_ff;
      time_in         = time_ff;
      quantum_in      = csr_write_en ? csr_write_data : quantum_ff;
      srch_cnt_in     = srch_cnt_ff;

      rsp_valid_in    = rsp_valid_ff && rsp_stall;
      status_in       = status_ff;
      run_id_in       = run_id_ff;
      run_prio_in     = run_prio_ff;
      finished_in     = finished_ff;
      finish_time_in  = finish_time_ff;
      preempted_in    = preempted_ff;

      ctl             = '0;
      ctl.count       = count_ff;
      push_a          = new_entry;
      push_b          = active_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd_in   = req_cmd;
               id_in    = req_task_id[ID_BITS-1:0];
               prio_in  = req_task_priority[PRIO_BITS-1:0];
               burst_in = req_burst[BURST_BITS-1:0];
               state_in = S_EXEC;
            end
         end
         S_EXEC: begin
            if (cmd_ff == CMD_ARRIVE) begin
               if (out_free) begin
                  rsp_valid_in   = 1'b1;
                  run_id_in      = '0;
                  run_prio_in    = '0;
                  finished_in    = 1'b0;
                  finish_time_in = '0;
                  preempted_in   = 1'b0;
                  if (burst_ff == '0 || held >= CNT_BITS'(QUEUE_DEPTH)) begin
                     status_in = STATUS_REJECT;
                  end else begin
                     status_in    = STATUS_ACCEPT;
                     ctl.push_one = 1'b1;
                     ctl.push_idx = count_ff;
                     if (active_valid_ff && prio_ff > active_ff.prio) begin
                        ctl.push_two    = 1'b1;
                        active_valid_in = 1'b0;
                        slice_in        = '0;
                        count_in        = count_ff + CNT_BITS'(2);
                        preempted_in    = 1'b1;
                     end else begin
                        count_in = count_ff + 1'b1;
                     end
                  end
                  state_in = S_IDLE;
               end
            end else if (!active_valid_ff && count_ff != '0) begin
               srch_cnt_in = '0;
               state_in    = S_SEARCH;
            end else begin
               state_in = S_RUN;
            end
         end
         S_SEARCH: begin
            srch_cnt_in = srch_cnt_ff + 1'b1;
            if (srch_cnt_ff == IDX_BITS'(QUEUE_DEPTH - 1)) begin
               state_in = S_EXTRACT;
            end
         end
         S_EXTRACT: begin
            active_in       = cell_wave[QUEUE_DEPTH-1].entry;
            ctl.shift       = 1'b1;
            ctl.shift_from  = cell_wave[QUEUE_DEPTH-1].idx;
            count_in        = count_ff - 1'b1;
            active_valid_in = 1'b1;
            slice_in        = '0;
            state_in        = S_RUN;
         end
         S_RUN: begin
            if (out_free) begin
               rsp_valid_in   = 1'b1;
               run_id_in      = '0;
               run_prio_in    = '0;
               finished_in    = 1'b0;
               finish_time_in = '0;
               preempted_in   = 1'b0;
               if (active_valid_ff) begin
                  status_in   = STATUS_RAN;
                  run_id_in   = 8'(active_ff.id);
                  run_prio_in = 8'(active_ff.prio);
                  if (rem_next == '0) begin
                     finished_in     = 1'b1;
                     finish_time_in  = time_ff + 1'b1;
                     active_valid_in = 1'b0;
                     slice_in        = '0;
                  end else if (slice_next >= limit) begin
                     // quantum used up: back of the queue
                     push_a.id        = active_ff.id;
                     push_a.prio      = active_ff.prio;
                     push_a.remaining = rem_next;
                     ctl.push_one     = 1'b1;
                     ctl.push_idx     = count_ff;
                     count_in         = count_ff + 1'b1;
                     active_valid_in  = 1'b0;
                     slice_in         = '0;
                  end else begin
                     active_in.remaining = rem_next;
                     slice_in            = slice_next;
                  end
               end else begin
                  status_in = STATUS_IDLE;
               end
               time_in  = time_ff + 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         count_ff        <= '0;
         active_valid_ff <= 1'b0;
         active_ff       <= '0;
         slice_ff        <= '0;
         time_ff         <= '0;
         quantum_ff      <= QUANTUM_RESET;
         srch_cnt_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         count_ff        <= count_in;
         active_valid_ff <= active_valid_in;
         active_ff       <= active_in;
         slice_ff        <= slice_in;
         time_ff         <= time_in;
         quantum_ff      <= quantum_in;
         srch_cnt_ff     <= srch_cnt_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff         <= cmd_in;
      id_ff          <= id_in;
      prio_ff        <= prio_in;
      burst_ff       <= burst_in;
      status_ff      <= status_in;
      run_id_ff      <= run_id_in;
      run_prio_ff    <= run_prio_in;
      finished_ff    <= finished_in;
      finish_time_ff <= finish_time_in;
      preempted_ff   <= preempted_in;
   end

   assign req_stall        = (state_ff != S_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_run_id       = run_id_ff;
   assign rsp_run_priority = run_prio_ff;
   assign rsp_finished     = finished_ff;
   assign rsp_finish_time  = finish_time_ff;
   assign rsp_preempted    = preempted_ff;

endmodule

// ===== design/prrs_checker.sv =====
// ----------------------------------------------------------------------------
// prrs_checker
// port level checks of the scheduler core, bound to the top level
// ----------------------------------------------------------------------------
module prrs_checker
   import prrs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_status,
   input logic [7:0]  rsp_run_id,
   input logic [7:0]  rsp_run_priority,
   input logic        rsp_finished,
   input logic [31:0] rsp_finish_time,
   input logic        rsp_preempted
);

   // stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status)
         && $stable(rsp_run_id) && $stable(rsp_finish_time))
      else $error("stalled result changed");

   // one item at a time: busy right after a transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("transfer taken while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_finished |-> rsp_status == STATUS_RAN)
      else $error("finish without a run");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_preempted |-> rsp_status == STATUS_ACCEPT)
      else $error("preemption without accepted arrival");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != STATUS_RAN |-> rsp_run_id == 8'd0
         && rsp_run_priority == 8'd0 && rsp_finish_time == 32'd0)
      else $error("run fields set without a run");

endmodule

bind priority_round_robin_scheduler_core prrs_checker u_prrs_checker (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_stall        (req_stall),
   .rsp_valid        (rsp_valid),
   .rsp_stall        (rsp_stall),
   .rsp_status       (rsp_status),
   .rsp_run_id       (rsp_run_id),
   .rsp_run_priority (rsp_run_priority),
   .rsp_finished     (rsp_finished),
   .rsp_finish_time  (rsp_finish_time),
   .rsp_preempted    (rsp_preempted)
);

// ===== bench/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the preemptive priority round robin scheduler: a
// scheduler model in the bench predicts every result from the accepted
// transfers, directed arrival and tick sequences come first, then random task
// traffic under several quanta, gap and stall mixes, a full queue and a long
// result hold-off
// ----------------------------------------------------------------------------
module tb_top
   import prrs_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int HOLD_CYCLES    = 300;
   localparam int SETTLE_CYCLES  = QUEUE_DEPTH + 8;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int REPORT_LIMIT   = 10;

   typedef struct {
      logic [1:0]           status;
      logic [ID_BITS-1:0]   run_id;
      logic [PRIO_BITS-1:0] run_priority;
      logic                 finished;
      logic [TIME_BITS-1:0] finish_time;
      logic                 preempted;
      realtime              accepted_at;
   } sched_result_type;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_cmd = CMD_TICK;
   logic [ID_BITS-1:0]    req_task_id = '0;
   logic [PRIO_BITS-1:0]  req_task_priority = '0;
   logic [BURST_BITS-1:0] req_burst = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic [1:0]            rsp_status;
   logic [ID_BITS-1:0]    rsp_run_id;
   logic [PRIO_BITS-1:0]  rsp_run_priority;
   logic                  rsp_finished;
   logic [TIME_BITS-1:0]  rsp_finish_time;
   logic                  rsp_preempted;
   logic                  csr_write_en = 1'b0;
   logic [7:0]            csr_write_data = '0;

   // scheduler model state
   entry_type             ready_tasks[$];
   entry_type             running;
   logic                  running_valid;
   logic [7:0]            slice_used;
   logic [TIME_BITS-1:0]  time_units;
   logic [7:0]            quantum_reg;

   sched_result_type      expected_results[$];

   int                    sender_gap_pct = 0;
   int                    rsp_stall_pct = 0;
   int                    hold_requests = 0;
   int                    holds_done = 0;
   int                    hold_left = 0;
   int                    idle_cycles = 0;
   int                    failures = 0;

   int                    items_sent = 0;
   int                    arrivals_taken = 0;
   int                    arrivals_refused = 0;
   int                    full_refusals = 0;
   int                    preemptions = 0;
   int                    ticks_ran = 0;
   int                    ticks_idle = 0;
   int                    completions = 0;
   int                    requeues = 0;
   int                    quantum_writes = 0;

   priority_round_robin_scheduler_core dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_cmd           (req_cmd),
      .req_task_id       (req_task_id),
      .req_task_priority (req_task_priority),
      .req_burst         (req_burst),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_run_id        (rsp_run_id),
      .rsp_run_priority  (rsp_run_priority),
      .rsp_finished      (rsp_finished),
      .rsp_finish_time   (rsp_finish_time),
      .rsp_preempted     (rsp_preempted),
      .csr_write_en      (csr_write_en),
      .csr_write_data    (csr_write_data)
   );

   always #4 clock = ~clock;

   function automatic int tasks_held();
      return ready_tasks.size() + (running_valid ? 1 : 0);
   endfunction

   function automatic void note_failure(input string msg);
      failures++;
      if (failures <= REPORT_LIMIT) begin
         $display("%0t: %s", $realtime, msg);
      end
   endfunction

   task automatic schedule_step(input logic cmd, input logic [ID_BITS-1:0] id,
                                input logic [PRIO_BITS-1:0] prio,
                                input logic [BURST_BITS-1:0] burst,
                                output sched_result_type r);
      entry_type  fresh;
      int         best;
      logic [7:0] limit;
      r = '{status: STATUS_ACCEPT, run_id: '0, run_priority: '0, finished: 1'b0,
            finish_time: '0, preempted: 1'b0, accepted_at: 0.0};
      if (cmd == CMD_ARRIVE) begin
         fresh.id = id;
         fresh.prio = prio;
         fresh.remaining = burst;
         if (burst == '0 || tasks_held() >= QUEUE_DEPTH) begin
            r.status = STATUS_REJECT;
            arrivals_refused++;
            if (burst != '0) full_refusals++;
         end else begin
            ready_tasks.insert(ready_tasks.size(), fresh);
            if (running_valid && prio > running.prio) begin
               ready_tasks.insert(ready_tasks.size(), running);
               running_valid = 1'b0;
               slice_used = '0;
               r.preempted = 1'b1;
               preemptions++;
            end
            arrivals_taken++;
         end
      end else begin
         if (!running_valid && ready_tasks.size() > 0) begin
            best = 0;
            for (int k = 1; k < ready_tasks.size(); k++) begin
               if (ready_tasks[k].prio > ready_tasks[best].prio) best = k;
            end
            running = ready_tasks[best];
            ready_tasks.delete(best);
            running_valid = 1'b1;
            slice_used = '0;
         end
         if (running_valid) begin
            limit = (quantum_reg == '0) ? 8'd1 : quantum_reg;
            r.status = STATUS_RAN;
            r.run_id = running.id;
            r.run_priority = running.prio;
            running.remaining = running.remaining - 1'b1;
            slice_used = slice_used + 1'b1;
            ticks_ran++;
            if (running.remaining == '0) begin
               r.finished = 1'b1;
               r.finish_time = time_units + 1'b1;
               running_valid = 1'b0;
               slice_used = '0;
               completions++;
            end else if (slice_used >= limit) begin
               ready_tasks.insert(ready_tasks.size(), running);
               running_valid = 1'b0;
               slice_used = '0;
               requeues++;
            end
         end else begin
            r.status = STATUS_IDLE;
            ticks_idle++;
         end
         time_units = time_units + 1'b1;
      end
   endtask

   // result check
   always @(posedge clock) begin
      sched_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_results.size() == 0 || expected_results[0].accepted_at == $realtime) begin
            note_failure($sformatf("unexpected result: status %0d id %0d prio %0d",
                                   rsp_status, rsp_run_id, rsp_run_priority));
         end else begin
            want = expected_results.pop_front();
            if (want.status !== rsp_status || want.run_id !== rsp_run_id ||
                want.run_priority !== rsp_run_priority || want.finished !== rsp_finished ||
                want.finish_time !== rsp_finish_time || want.preempted !== rsp_preempted) begin
               note_failure($sformatf({"mismatch: exp st %0d id %0d pr %0d fin %0d ft %0d pre %0d",
                                       " / got st %0d id %0d pr %0d fin %0d ft %0d pre %0d"},
                  want.status, want.run_id, want.run_priority, want.finished,
                  want.finish_time, want.preempted, rsp_status, rsp_run_id,
                  rsp_run_priority, rsp_finished, rsp_finish_time, rsp_preempted));
            end
         end
      end
   end

   // result side stall, with a counted long hold-off on request
   always @(posedge clock) begin
      if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (holds_done != hold_requests) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         holds_done <= holds_done + 1;
      end else begin
         rsp_stall <= (int'($urandom_range(99)) < rsp_stall_pct);
      end
   end

   // watchdog on cycles without any transfer
   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("[priority_round_robin_scheduler_core] ERROR");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   task automatic send_item(input logic cmd, input logic [ID_BITS-1:0] id,
                            input logic [PRIO_BITS-1:0] prio,
                            input logic [BURST_BITS-1:0] burst);
      int               gap;
      sched_result_type r;
      gap = 0;
      while (gap < 40 && int'($urandom_range(99)) < sender_gap_pct) gap++;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_cmd <= cmd;
      req_task_id <= id;
      req_task_priority <= prio;
      req_burst <= burst;
      do @(posedge clock); while (req_stall);
      schedule_step(cmd, id, prio, burst, r);
      r.accepted_at = $realtime;
      expected_results.insert(expected_results.size(), r);
      items_sent++;
   endtask

   task automatic send_tick();
      send_item(CMD_TICK, ID_BITS'($urandom), PRIO_BITS'($urandom), BURST_BITS'($urandom));
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_quantum(input logic [7:0] q);
      csr_write_en <= 1'b1;
      csr_write_data <= q;
      @(posedge clock);
      csr_write_en <= 1'b0;
      csr_write_data <= 8'($urandom);
      quantum_reg = q;
      quantum_writes++;
   endtask

   task automatic random_item(input int arrive_pct, input int prio_span);
      logic [BURST_BITS-1:0] burst;
      if (tasks_held() >= QUEUE_DEPTH && $urandom_range(3) == 0) begin
         send_item(CMD_ARRIVE, ID_BITS'($urandom), PRIO_BITS'($urandom),
                   BURST_BITS'($urandom));
      end else if (int'($urandom_range(99)) < arrive_pct) begin
         case ($urandom_range(24))
            0:       burst = '0;
            1:       burst = BURST_BITS'($urandom_range(13, 40));
            default: burst = BURST_BITS'($urandom_range(1, 12));
         endcase
         send_item(CMD_ARRIVE, ID_BITS'($urandom), PRIO_BITS'($urandom_range(prio_span)),
                   burst);
      end else begin
         send_tick();
      end
   endtask

   // quantum default 4: idle cpu, zero burst, extreme fields, preemption,
   // equal priority without preemption, round robin at the quantum
   task automatic test_directed();
      send_tick();
      send_item(CMD_ARRIVE, 8'h5A, 8'd3, 16'd0);
      send_item(CMD_ARRIVE, 8'hFF, 8'hFF, 16'd1);
      send_tick();
      send_item(CMD_ARRIVE, 8'h00, 8'h00, 16'hFFFF);
      send_tick();
      send_item(CMD_ARRIVE, 8'h11, 8'h80, 16'd2);
      send_item(CMD_ARRIVE, 8'h12, 8'h80, 16'd5);
      send_tick();
      send_item(CMD_ARRIVE, 8'h13, 8'h80, 16'd3);
      repeat (10) send_tick();
      drain_results();
   endtask

   task automatic test_random_mix(input logic [7:0] q, input int gap_pct,
                                  input int stall_pct, input int count);
      int sent;
      int run_len;
      int arrive_pct;
      int span;
      drain_results();
      write_quantum(q);
      sender_gap_pct = gap_pct;
      rsp_stall_pct <= stall_pct;
      sent = 0;
      while (sent < count) begin
         run_len = $urandom_range(8, 30);
         case ($urandom_range(2))
            0:       arrive_pct = 30;
            1:       arrive_pct = 50;
            default: arrive_pct = 70;
         endcase
         span = $urandom_range(1) ? 255 : 3;
         repeat (run_len) begin
            random_item(arrive_pct, span);
            sent++;
         end
      end
      drain_results();
   endtask

   task automatic test_fill_and_drain();
      int guard;
      write_quantum(8'd4);
      sender_gap_pct = 10;
      rsp_stall_pct <= 10;
      while (tasks_held() < QUEUE_DEPTH) begin
         send_item(CMD_ARRIVE, ID_BITS'($urandom), PRIO_BITS'($urandom_range(1, 255)),
                   BURST_BITS'($urandom_range(1, 6)));
      end
      repeat (4) begin
         send_item(CMD_ARRIVE, ID_BITS'($urandom), PRIO_BITS'($urandom),
                   BURST_BITS'($urandom));
      end
      guard = 0;
      while (tasks_held() > 1 && guard < 300) begin
         send_tick();
         guard++;
      end
      drain_results();
   endtask

   task automatic test_backpressure();
      write_quantum(8'd3);
      sender_gap_pct = 0;
      rsp_stall_pct <= 0;
      hold_requests <= hold_requests + 1;
      repeat (24) random_item(50, 7);
      drain_results();
   endtask

   initial begin
      ready_tasks.delete();
      running = '0;
      running_valid = 1'b0;
      slice_used = '0;
      time_units = '0;
      quantum_reg = QUANTUM_RESET;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_directed();
      test_random_mix(8'd1, 0, 0, 75);
      test_random_mix(8'd255, 85, 0, 75);
      test_random_mix(8'd0, 0, 85, 75);
      test_random_mix(8'($urandom_range(2, 8)), 25, 25, 75);
      test_fill_and_drain();
      test_backpressure();

      $display("covered %0d transfers over %0d quantum settings: %0d arrivals taken,",
               items_sent, quantum_writes, arrivals_taken);
      $display("%0d refused (%0d on a full queue), %0d preemptions, %0d ticks ran,",
               arrivals_refused, full_refusals, preemptions, ticks_ran);
      $display("%0d idle ticks, %0d completions, %0d requeues at the quantum",
               ticks_idle, completions, requeues);
      if (failures == 0 && expected_results.size() == 0) begin
         $display("[priority_round_robin_scheduler_core] OK");
      end else begin
         $display("[priority_round_robin_scheduler_core] ERROR");
      end
      $finish;
   end

endmodule
